// File: src/xtea_pkg.sv
// Shared constants, payload types and round helpers for the XTEA pipeline.
`timescale 1ns / 1ps

package xtea_pkg;

   // Cipher geometry
   localparam int ROUNDS      = 32;
   localparam int STAGES      = 2 * ROUNDS;
   localparam int KEY_WORDS   = 4;
   localparam int KEY_IDX_W   = $clog2(KEY_WORDS);
   localparam int SHIFT_LEFT  = 4;
   localparam int SHIFT_RIGHT = 5;
   localparam int KEY_SHIFT   = 11;

   typedef logic [31:0] word_type;
   typedef logic [KEY_IDX_W-1:0] key_idx_type;

   localparam word_type DELTA = 32'h9E3779B9;

   // Command codes
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   // Request and response payloads
   typedef struct packed {
      logic     cmd;
      word_type block_left;
      word_type block_right;
   } xtea_req_type;

   typedef struct packed {
      word_type result_left;
      word_type result_right;
   } xtea_rsp_type;

   // Running sum after a given number of rounds, wrapping modulo 2^32
   function automatic word_type round_sum(input int rnd);
      round_sum = DELTA * word_type'(rnd);
   endfunction

   // Sum used by half-round stage h when enciphering
   function automatic word_type enc_sum(input int h);
      if ((h % 2) == 0) begin
         enc_sum = round_sum(h / 2);
      end else begin
         enc_sum = round_sum(h / 2 + 1);
      end
   endfunction

   // Sum used by half-round stage h when deciphering
   function automatic word_type dec_sum(input int h);
      if ((h % 2) == 0) begin
         dec_sum = round_sum(ROUNDS - h / 2);
      end else begin
         dec_sum = round_sum(ROUNDS - h / 2 - 1);
      end
   endfunction

   // Key word index from either the low sum bits or the bits above KEY_SHIFT
   function automatic key_idx_type key_sel(input word_type sum, input logic use_high);
      word_type shifted;
      shifted = use_high ? (sum >> KEY_SHIFT) : sum;
      key_sel = shifted[KEY_IDX_W-1:0];
   endfunction

   // XTEA mixing function
   function automatic word_type mix(input word_type x, input word_type sum,
                                    input word_type kw);
      word_type t;
      t   = ((x << SHIFT_LEFT) ^ (x >> SHIFT_RIGHT)) + x;
      mix = t ^ (sum + kw);
   endfunction

endpackage

// File: src/xtea_block_cipher_top.sv
// XTEA encipher/decipher engine, one half-round per pipeline stage.
//
//   channel  ports                         direction  transfer when
//   request  start, busy, req_data         in         start && !busy
//   response rsp_valid, rsp_data           out        rsp_valid (one cycle)
//   csr      csr_write, csr_index, csr_wdata in       csr_write
//
// One block enters every cycle; each result passes through 2 * ROUNDS
// half-round stages, each an adder chain of one mix and one add.
// busy is always low: the stage chain advances every cycle and never holds.
// The receiver cannot stall, so no result is ever held back.
// Synchronous reset clears stage valid bits and key words, not data registers.
// The user must write keys only while the pipeline is empty; it is not enforced.
`timescale 1ns / 1ps

module xtea_block_cipher_top
   import xtea_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  xtea_req_type req_data,
   output logic         rsp_valid,
   output xtea_rsp_type rsp_data,
   input  logic         csr_write,
   input  key_idx_type  csr_index,
   input  word_type     csr_wdata
);

   word_type     keys_ff [KEY_WORDS];
   xtea_req_type stage_ff [STAGES];
   xtea_req_type stage_in [STAGES];
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;

   // Never hold off a request
   assign busy = 1'b0;

   // Key word registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            keys_ff[i] <= '0;
         end
      end else if (csr_write) begin
         keys_ff[csr_index] <= csr_wdata;
      end
   end

   // Half-round stages
   for (genvar h = 0; h < STAGES; h++) begin : g_stage
      localparam logic        ODD     = 1'((h % 2) == 1);
      localparam word_type    ENC_SUM = enc_sum(h);
      localparam word_type    DEC_SUM = dec_sum(h);
      localparam key_idx_type ENC_KEY = key_sel(ENC_SUM, ODD);
      localparam key_idx_type DEC_KEY = key_sel(DEC_SUM, !ODD);

      xtea_req_type src;
      logic         src_valid;
      logic         take_left;
      word_type     source;
      word_type     target;
      word_type     mixed;
      word_type     updated;

      // Pick the stage input: request port for the first stage
      if (h == 0) begin : g_first
         assign src       = req_data;
         assign src_valid = start && !busy;
      end else begin : g_next
         assign src       = stage_ff[h-1];
         assign src_valid = valid_ff[h-1];
      end

      // Mix one half into the other; decipher subtracts
      always_comb begin
         take_left = src.cmd ^ ODD;
         source    = take_left ? src.block_left : src.block_right;
         target    = take_left ? src.block_right : src.block_left;
         if (src.cmd == CMD_DECRYPT) begin
            mixed   = mix(source, DEC_SUM, keys_ff[DEC_KEY]);
            updated = target - mixed;
         end else begin
            mixed   = mix(source, ENC_SUM, keys_ff[ENC_KEY]);
            updated = target + mixed;
         end
         stage_in[h] = src;
         if (take_left) begin
            stage_in[h].block_right = updated;
         end else begin
            stage_in[h].block_left = updated;
         end
         valid_in[h] = src_valid;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Advance stage data
   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         stage_ff[i] <= stage_in[i];
      end
   end

   // Drive the response from the last stage
   assign rsp_valid             = valid_ff[STAGES-1];
   assign rsp_data.result_left  = stage_ff[STAGES-1].block_left;
   assign rsp_data.result_right = stage_ff[STAGES-1].block_right;

`ifndef ASSERT_OFF
   // Every transfer in comes out after the full stage count
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##STAGES rsp_valid)
      else $error("request lost in pipeline");

   // No response appears without a request that entered the stage chain
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##STAGES !rsp_valid)
      else $error("response without request");

   // Reset empties the pipeline at once
   a_reset_flush: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not flushed by reset");
`endif

endmodule
